[src/xrr_pkg.sv]
// Package for the xoroshiro128+ generator with bounded draws.
// Holds command codes, generator constants and the controller/datapath structs.
// No dependencies.
package xrr_pkg;

    // Command codes carried in the op field.
    localparam logic [1:0] OP_RAW     = 2'd0;
    localparam logic [1:0] OP_BOUNDED = 2'd1;
    localparam logic [1:0] OP_JUMP    = 2'd2;
    localparam logic [1:0] OP_SEED    = 2'd3;

    // Result kind codes.
    localparam logic KIND_RAW     = 1'b0;
    localparam logic KIND_BOUNDED = 1'b1;

    // Generator reset state and jump polynomial.
    localparam logic [63:0] RESET_WORD_A = 64'h7c87b3fced63be76;
    localparam logic [63:0] RESET_WORD_B = 64'h4ec3c3191d40a751;
    localparam logic [63:0] JUMP_LO      = 64'hbeac0467eba5facb;
    localparam logic [63:0] JUMP_HI      = 64'hd86b048b86aa9922;

    // Rotation and shift amounts of the state update.
    localparam int ROT_A   = 55;
    localparam int SHIFT_A = 14;
    localparam int ROT_B   = 36;

    // Width of the bounded draw arithmetic, jump step count and jump bit index width.
    localparam int RANGE_W = 33;
    localparam int JUMP_STEPS = 128;
    localparam int JIDX_W  = $clog2(JUMP_STEPS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_bounds;
        logic load_seed;
        logic prep;
        logic advance;
        logic jump_step;
        logic jump_finish;
        logic emit_raw;
        logic emit_bounded;
        logic emit_empty;
    } xrr_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cand_ok;
        logic empty;
        logic idx_last;
        logic out_free;
    } xrr_stat_t;

endpackage

[src/xrr_cmd_if.sv]
// Command channel interface: valid/ready handshake plus command payload.
// Depends on nothing.
interface xrr_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [63:0]        seed_word;

    modport source (output valid, output op, output range_low, output range_high,
                    output seed_word, input ready);
    modport sink   (input valid, input op, input range_low, input range_high,
                    input seed_word, output ready);
endinterface

[src/xrr_res_if.sv]
// Result channel interface: valid/ready handshake plus result payload.
// Depends on nothing.
interface xrr_res_if;
    logic               valid;
    logic               ready;
    logic [63:0]        raw_value;
    logic signed [31:0] bounded_value;
    logic               kind;

    modport source (output valid, output raw_value, output bounded_value, output kind,
                    input ready);
    modport sink   (input valid, input raw_value, input bounded_value, input kind,
                    output ready);
endinterface

[src/xrr_datapath.sv]
// Datapath: generator state, jump accumulators, bounded draw range logic
// and the result register. Depends on xrr_pkg.
module xrr_datapath
    import xrr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  xrr_ctrl_t          ctrl,
    output xrr_stat_t          stat,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    input  logic [63:0]        seed_word,
    input  logic               res_ready,
    output logic               res_valid,
    output logic [63:0]        raw_value,
    output logic signed [31:0] bounded_value,
    output logic               kind
);

    logic [63:0]        word_a_reg, word_b_reg;
    logic [63:0]        acc_a_reg, acc_b_reg;
    logic [JIDX_W-1:0]  idx_reg;
    logic [31:0]        lo_reg, hi_reg;
    logic [RANGE_W-1:0] range_reg, mask_reg;
    logic               out_valid_reg;
    logic [63:0]        raw_reg;
    logic [31:0]        bounded_reg;
    logic               kind_reg;

    logic [63:0]        sum;
    logic [63:0]        mix;
    logic [63:0]        step_a, step_b;
    logic [33:0]        diff;
    logic [RANGE_W-1:0] range_calc, mask_calc, cand;
    logic [127:0]       poly;
    logic               poly_bit;
    logic               out_free;

    // One generator step from the current state.
    always_comb
    begin
        sum    = word_a_reg + word_b_reg;
        mix    = word_a_reg ^ word_b_reg;
        step_a = {word_a_reg[63-ROT_A:0], word_a_reg[63:64-ROT_A]} ^ mix ^ (mix << SHIFT_A);
        step_b = {mix[63-ROT_B:0], mix[63:64-ROT_B]};
    end

    // Range of the bounds, and the mask to the next power of two above it.
    always_comb
    begin
        diff       = {{2{hi_reg[31]}}, hi_reg} - {{2{lo_reg[31]}}, lo_reg};
        range_calc = diff[RANGE_W-1:0] + {{(RANGE_W-1){1'b0}}, 1'b1};
        mask_calc  = range_calc;
        mask_calc  = mask_calc | (mask_calc >> 1);
        mask_calc  = mask_calc | (mask_calc >> 2);
        mask_calc  = mask_calc | (mask_calc >> 4);
        mask_calc  = mask_calc | (mask_calc >> 8);
        mask_calc  = mask_calc | (mask_calc >> 16);
        mask_calc  = mask_calc | (mask_calc >> 32);
        cand       = sum[RANGE_W-1:0] & mask_reg;
    end

    assign poly     = {JUMP_HI, JUMP_LO};
    assign poly_bit = poly[idx_reg];
    assign out_free = !out_valid_reg || res_ready;

    // Status back to the controller.
    always_comb
    begin
        stat.cand_ok  = (cand < range_reg);
        stat.empty    = diff[33];
        stat.idx_last = (idx_reg == JIDX_W'(JUMP_STEPS - 1));
        stat.out_free = out_free;
    end

    // Generator state, jump accumulators and bit index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_a_reg <= RESET_WORD_A;
            word_b_reg <= RESET_WORD_B;
            acc_a_reg  <= '0;
            acc_b_reg  <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            if (ctrl.load_seed)
            begin
                word_a_reg <= seed_word;
            end
            else if (ctrl.jump_finish)
            begin
                word_a_reg <= acc_a_reg;
                word_b_reg <= acc_b_reg;
                acc_a_reg  <= '0;
                acc_b_reg  <= '0;
                idx_reg    <= '0;
            end
            else if (ctrl.jump_step)
            begin
                if (poly_bit)
                begin
                    acc_a_reg <= acc_a_reg ^ word_a_reg;
                    acc_b_reg <= acc_b_reg ^ word_b_reg;
                end
                word_a_reg <= step_a;
                word_b_reg <= step_b;
                idx_reg    <= idx_reg + JIDX_W'(1);
            end
            else if (ctrl.advance)
            begin
                word_a_reg <= step_a;
                word_b_reg <= step_b;
            end
        end
    end

    // Bounds captured at transfer, range and mask captured in the prep cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.latch_bounds)
        begin
            lo_reg <= range_low;
            hi_reg <= range_high;
        end
        if (ctrl.prep)
        begin
            range_reg <= range_calc;
            mask_reg  <= mask_calc;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit_raw || ctrl.emit_bounded || ctrl.emit_empty)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (ctrl.emit_raw)
        begin
            raw_reg     <= sum;
            bounded_reg <= '0;
            kind_reg    <= KIND_RAW;
        end
        else if (ctrl.emit_bounded)
        begin
            raw_reg     <= '0;
            bounded_reg <= lo_reg + cand[31:0];
            kind_reg    <= KIND_BOUNDED;
        end
        else if (ctrl.emit_empty)
        begin
            raw_reg     <= '0;
            bounded_reg <= '0;
            kind_reg    <= KIND_BOUNDED;
        end
    end

    assign res_valid     = out_valid_reg;
    assign raw_value     = raw_reg;
    assign bounded_value = bounded_reg;
    assign kind          = kind_reg;

endmodule

[src/xrr_ctrl.sv]
// Controller state machine: decodes commands and sequences draws,
// rejection retries and the jump. Depends on xrr_pkg.
module xrr_ctrl
    import xrr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  logic [1:0] cmd_op,
    output logic       cmd_ready,
    input  xrr_stat_t  stat,
    output xrr_ctrl_t  ctrl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RAW  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DRAW = 3'd3;
    localparam logic [2:0] S_JUMP = 3'd4;
    localparam logic [2:0] S_JFIN = 3'd5;

    logic [2:0] state_reg, state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        cmd_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    unique case (cmd_op)
                        OP_RAW:
                        begin
                            state_next = S_RAW;
                        end
                        OP_BOUNDED:
                        begin
                            ctrl.latch_bounds = 1'b1;
                            state_next        = S_PREP;
                        end
                        OP_JUMP:
                        begin
                            state_next = S_JUMP;
                        end
                        OP_SEED:
                        begin
                            ctrl.load_seed = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RAW:
            begin
                if (stat.out_free)
                begin
                    ctrl.emit_raw = 1'b1;
                    ctrl.advance  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_PREP:
            begin
                if (stat.empty)
                begin
                    if (stat.out_free)
                    begin
                        ctrl.emit_empty = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    ctrl.prep  = 1'b1;
                    state_next = S_DRAW;
                end
            end
            S_DRAW:
            begin
                // A rejected candidate costs one step; an accepted one waits
                // for room in the result register.
                if (stat.cand_ok)
                begin
                    if (stat.out_free)
                    begin
                        ctrl.emit_bounded = 1'b1;
                        ctrl.advance      = 1'b1;
                        state_next        = S_IDLE;
                    end
                end
                else
                begin
                    ctrl.advance = 1'b1;
                end
            end
            S_JUMP:
            begin
                ctrl.jump_step = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_JFIN;
                end
            end
            S_JFIN:
            begin
                ctrl.jump_finish = 1'b1;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/xoroshiro128plus_rng_with_range_top.sv]
// Top level of the xoroshiro128+ generator with bounded draws and jump.
// Depends on xrr_pkg, xrr_cmd_if, xrr_res_if, xrr_ctrl and xrr_datapath.
//
//  Channel  Dir  Payload                                  Transfer
//  cmd      in   op, range_low, range_high, seed_word     valid && ready
//  res      out  raw_value, bounded_value, kind           valid && ready
//
// A raw draw uses S_RAW; a bounded draw S_PREP and S_DRAW plus one step per rejected
// candidate (one generator step per cycle), or only S_PREP when the upper bound is
// below the lower; a jump takes 128 accumulation steps and one to load the result;
// a seed load completes in S_IDLE. Reset loads the fixed generator state and empties
// the result register. A finished result waits in the result register; the
// controller holds a following draw until it is free, so no step is lost on a stall.
module xoroshiro128plus_rng_with_range_top
    import xrr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    xrr_cmd_if.sink   cmd,
    xrr_res_if.source res
);

    xrr_ctrl_t ctrl;
    xrr_stat_t stat;

    xrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_op    (cmd.op),
        .cmd_ready (cmd.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    xrr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .range_low     (cmd.range_low),
        .range_high    (cmd.range_high),
        .seed_word     (cmd.seed_word),
        .res_ready     (res.ready),
        .res_valid     (res.valid),
        .raw_value     (res.raw_value),
        .bounded_value (res.bounded_value),
        .kind          (res.kind)
    );

endmodule
